@@ rtl/pf_pkg.sv @@
// shared types, constants and letter/square helper functions for the playfair block
package pf_pkg;

    localparam int unsigned LETTER_W = 5;
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned SQ_SIDE  = 5;
    localparam int unsigned SQ_CELLS = 25;
    localparam int unsigned LETTERS  = 26;
    localparam int unsigned POS_W    = 5;

    localparam logic [LETTER_W-1:0] LETTER_I  = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J  = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X  = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_Z  = 5'd25;
    localparam logic [LETTER_W-1:0] LETTER_NUM = 5'(LETTERS);
    localparam logic [POS_W-1:0]    CELL_NUM  = 5'(SQ_CELLS);

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_KEY    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_MSG    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_END    = 3'd4;

    typedef struct packed {
        logic                we;
        logic [POS_W-1:0]    waddr;
        logic [LETTER_W-1:0] wdata;
        logic                re;
        logic [POS_W-1:0]    raddr;
    } t_mem_req;

    function automatic logic [LETTER_W-1:0] pf_fold(input logic [LETTER_W-1:0] l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

    function automatic logic [2:0] pf_row(input logic [POS_W-1:0] p);
        logic [2:0] r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [2:0] pf_col(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] t;
        t = p - {2'b00, pf_row(p)} * 5'(SQ_SIDE);
        return t[2:0];
    endfunction

    function automatic logic [2:0] pf_next(input logic [2:0] c);
        return (c == 3'(SQ_SIDE - 1)) ? 3'd0 : c + 3'd1;
    endfunction

    function automatic logic [POS_W-1:0] pf_cell(input logic [2:0] r, input logic [2:0] c);
        return {2'b00, r} * 5'(SQ_SIDE) + {2'b00, c};
    endfunction

endpackage

@@ rtl/pf_ram.sv @@
// generic single-write single-read ram with registered read data
module pf_ram #(
    parameter int unsigned WIDTH = 5,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pf_ctrl.sv @@
// sequencer: key fill, pairing, square lookups and output register
module pf_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pf_pkg::ACTION_W-1:0]   i_action,
    input  logic [pf_pkg::LETTER_W-1:0]   i_letter,
    input  logic                          i_cfg_valid,
    input  logic [pf_pkg::LETTER_W-1:0]   i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pf_pkg::LETTER_W-1:0]   o_first,
    output logic [pf_pkg::LETTER_W-1:0]   o_second,
    output logic                          o_padded,
    output pf_pkg::t_mem_req              o_lp_req,
    input  logic [pf_pkg::POS_W-1:0]      i_lp_rdata,
    output pf_pkg::t_mem_req              o_ks_req,
    input  logic [pf_pkg::LETTER_W-1:0]   i_ks_rdata
);
    import pf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_LA,
        S_LB,
        S_SQ1,
        S_SQ2,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [LETTERS-1:0]  r_used, n_used;
    logic [POS_W-1:0]    r_fill, n_fill;
    logic                r_key_ready, n_key_ready;
    logic [LETTER_W-1:0] r_held, n_held;
    logic                r_held_valid, n_held_valid;
    logic [LETTER_W-1:0] r_walk, n_walk;
    logic [LETTER_W-1:0] r_a, n_a;
    logic [LETTER_W-1:0] r_b, n_b;
    logic                r_pad_flag, n_pad_flag;
    logic [POS_W-1:0]    r_pa, n_pa;
    logic [POS_W-1:0]    r_q, n_q;
    logic [LETTER_W-1:0] r_x, n_x;
    logic [LETTER_W-1:0] r_pad, n_pad;
    logic                r_out_valid, n_out_valid;
    logic [LETTER_W-1:0] r_first, n_first;
    logic [LETTER_W-1:0] r_second, n_second;
    logic                r_padded, n_padded;

    logic                w_acc;
    logic [LETTER_W-1:0] w_in_fold;
    logic [LETTER_W-1:0] w_key_letter;
    logic                w_place;
    logic [LETTER_W-1:0] w_pad;
    logic [2:0]          w_ra, w_ca, w_rb, w_cb;
    logic [POS_W-1:0]    w_i1, w_i2;
    logic                w_out_free;

    assign w_acc      = i_in_valid && (r_state == S_IDLE);
    assign w_in_fold  = pf_fold(i_letter);
    assign w_key_letter = (r_state == S_FILL) ? r_walk : w_in_fold;
    assign w_pad      = (r_pad >= LETTER_NUM) ? LETTER_X : pf_fold(r_pad);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        logic try_place;
        try_place = (w_acc && i_action == ACT_KEY && !r_key_ready && i_letter < LETTER_NUM)
                 || (r_state == S_FILL && r_walk != LETTER_J);
        w_place = try_place && !r_used[w_key_letter] && (r_fill < CELL_NUM);
    end

    // corner, row and column rules on the two square positions
    always_comb begin
        w_ra = pf_row(r_pa);
        w_ca = pf_col(r_pa);
        w_rb = pf_row(i_lp_rdata);
        w_cb = pf_col(i_lp_rdata);
        if (w_ra == w_rb) begin
            w_i1 = pf_cell(w_ra, pf_next(w_ca));
            w_i2 = pf_cell(w_rb, pf_next(w_cb));
        end else if (w_ca == w_cb) begin
            w_i1 = pf_cell(pf_next(w_ra), w_ca);
            w_i2 = pf_cell(pf_next(w_rb), w_cb);
        end else begin
            w_i1 = pf_cell(w_ra, w_cb);
            w_i2 = pf_cell(w_rb, w_ca);
        end
    end

    always_comb begin
        o_lp_req.we    = w_place;
        o_lp_req.waddr = w_key_letter;
        o_lp_req.wdata = r_fill;
        o_lp_req.re    = (r_state == S_LA) || (r_state == S_LB);
        o_lp_req.raddr = (r_state == S_LA) ? r_a : r_b;
        o_ks_req.we    = w_place;
        o_ks_req.waddr = r_fill;
        o_ks_req.wdata = w_key_letter;
        o_ks_req.re    = (r_state == S_SQ1) || (r_state == S_SQ2);
        o_ks_req.raddr = (r_state == S_SQ1) ? w_i1 : r_q;
    end

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_fill       = r_fill;
        n_key_ready  = r_key_ready;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_walk       = r_walk;
        n_a          = r_a;
        n_b          = r_b;
        n_pad_flag   = r_pad_flag;
        n_pa         = r_pa;
        n_q          = r_q;
        n_x          = r_x;
        n_pad        = i_cfg_valid ? i_cfg_data : r_pad;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_first      = r_first;
        n_second     = r_second;
        n_padded     = r_padded;

        if (w_place) begin
            n_used[w_key_letter] = 1'b1;
            n_fill = r_fill + 5'd1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_action)
                        ACT_CLEAR: begin
                            n_used       = '0;
                            n_fill       = '0;
                            n_key_ready  = 1'b0;
                            n_held_valid = 1'b0;
                            n_held       = '0;
                        end
                        ACT_FINISH: begin
                            if (!r_key_ready) begin
                                n_walk  = '0;
                                n_state = S_FILL;
                            end
                        end
                        ACT_MSG: begin
                            if (r_key_ready && i_letter < LETTER_NUM) begin
                                if (!r_held_valid) begin
                                    n_held       = w_in_fold;
                                    n_held_valid = 1'b1;
                                end else begin
                                    n_a        = r_held;
                                    n_b        = (r_held == w_in_fold) ? w_pad : w_in_fold;
                                    n_pad_flag = 1'b0;
                                    if (r_held != w_in_fold) begin
                                        n_held_valid = 1'b0;
                                    end
                                    n_state = S_LA;
                                end
                            end
                        end
                        ACT_END: begin
                            if (r_key_ready && r_held_valid) begin
                                n_a          = r_held;
                                n_b          = w_pad;
                                n_pad_flag   = 1'b1;
                                n_held_valid = 1'b0;
                                n_state      = S_LA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (r_walk == LETTER_Z) begin
                    n_key_ready = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_walk = r_walk + 5'd1;
                end
            end
            S_LA: begin
                n_state = S_LB;
            end
            S_LB: begin
                n_pa    = i_lp_rdata;
                n_state = S_SQ1;
            end
            S_SQ1: begin
                n_q     = w_i2;
                n_state = S_SQ2;
            end
            S_SQ2: begin
                n_x     = i_ks_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_first     = r_x;
                    n_second    = i_ks_rdata;
                    n_padded    = r_pad_flag;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_fill       <= '0;
            r_key_ready  <= 1'b0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_pad        <= LETTER_X;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_fill       <= n_fill;
            r_key_ready  <= n_key_ready;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_pad        <= n_pad;
            r_out_valid  <= n_out_valid;
        end
        r_walk     <= n_walk;
        r_a        <= n_a;
        r_b        <= n_b;
        r_pad_flag <= n_pad_flag;
        r_pa       <= n_pa;
        r_q        <= n_q;
        r_x        <= n_x;
        r_first    <= n_first;
        r_second   <= n_second;
        r_padded   <= n_padded;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_first     = r_first;
    assign o_second    = r_second;
    assign o_padded    = r_padded;

endmodule

@@ rtl/playfair_digraph_cipher.sv @@
// top level of the playfair digraph cipher: sequencer and the two square memories
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid/s_axis_tready    tdata: action, letter
// m_axis    out        m_axis_tvalid/m_axis_tready    tdata: first, second; tuser: end_padded
// cfg       in         i_cfg_valid/o_cfg_ready        i_cfg_data: pad_letter
//
// clear, key letter, held message letter and ignored beats leave the sequencer idle
// finish key makes one walk step over each letter code
// a pair or an end flush makes two reads on the position memory port
// followed by two reads on the square memory port
// reset clears control state only; square contents are valid once the key is finished
// a waiting result holds the sequencer in its last step and stops input beats
module playfair_digraph_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // action[2:0], letter[7:3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // cipher_first[4:0], cipher_second[9:5], zeros
    output logic        m_axis_tuser,   // end_padded[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data      // pad_letter
);
    import pf_pkg::*;

    t_mem_req            w_lp_req;
    t_mem_req            w_ks_req;
    logic [POS_W-1:0]    w_lp_rdata;
    logic [LETTER_W-1:0] w_ks_rdata;
    logic [LETTER_W-1:0] w_first;
    logic [LETTER_W-1:0] w_second;

    pf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tdata[2:0]),
        .i_letter    (s_axis_tdata[7:3]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_first     (w_first),
        .o_second    (w_second),
        .o_padded    (m_axis_tuser),
        .o_lp_req    (w_lp_req),
        .i_lp_rdata  (w_lp_rdata),
        .o_ks_req    (w_ks_req),
        .i_ks_rdata  (w_ks_rdata)
    );

    // position of each letter in the square
    pf_ram #(
        .WIDTH (POS_W),
        .DEPTH (LETTERS)
    ) u_place_ram (
        .i_clk   (i_clk),
        .i_we    (w_lp_req.we),
        .i_waddr (w_lp_req.waddr),
        .i_wdata (w_lp_req.wdata),
        .i_re    (w_lp_req.re),
        .i_raddr (w_lp_req.raddr),
        .o_rdata (w_lp_rdata)
    );

    // letter at each square position
    pf_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (SQ_CELLS)
    ) u_square_ram (
        .i_clk   (i_clk),
        .i_we    (w_ks_req.we),
        .i_waddr (w_ks_req.waddr),
        .i_wdata (w_ks_req.wdata),
        .i_re    (w_ks_req.re),
        .i_raddr (w_ks_req.raddr),
        .o_rdata (w_ks_rdata)
    );

    assign m_axis_tdata = {6'b000000, w_second, w_first};
    assign o_cfg_ready  = 1'b1;

endmodule

@@ rtl/pf_check.sv @@
// port-level checks for the playfair digraph cipher, bound to the top level
module pf_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    a_out_letters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] != 5'd9 && m_axis_tdata[4:0] < 5'd26
                       && m_axis_tdata[9:5] != 5'd9 && m_axis_tdata[9:5] < 5'd26
                       && m_axis_tdata[15:10] == 6'd0)
        else $error("result beat holds a letter outside the square");

    a_no_direct_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result beat appeared straight after an input beat");

endmodule

bind playfair_digraph_cipher pf_check u_pf_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
